@@ src/w2e_pkg.sv @@
package w2e_pkg;

  localparam logic [5:0]  KIND_DATA   = 6'd2;
  localparam logic [5:0]  KIND_QOS    = 6'd34;
  localparam logic [5:0]  OFF_DATA    = 6'd32;
  localparam logic [5:0]  OFF_QOS     = 6'd34;
  localparam logic [5:0]  COUNT_CEIL  = 6'd34;
  localparam logic [5:0]  KIND_MASK   = 6'd63;
  localparam logic [15:0] SEQ_RESET   = 16'd123;
  localparam logic [15:0] ETYPE_WORD  = 16'h0008;

  localparam int ADDR_BYTES     = 12;
  localparam int HDR_LEN        = 14;
  localparam int W2E_FIFO_DEPTH = 4;

  // One queued command: a header burst (with its address snapshot) or a payload byte
  typedef struct packed {
    logic                      hdr;
    logic [7:0]                data;
    logic                      last;
    logic [ADDR_BYTES*8-1:0]   addr;
  } w2e_cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } w2e_push_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } w2e_pop_ctl_t;

endpackage

@@ src/w2e_if.sv @@
interface w2e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface w2e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ src/wifi_to_ethernet_decap_top.sv @@
// An accepted byte that produces output is written into the command queue and from there
// moved into the output register, where it waits until the sink takes it.
// Throughput: one byte per cycle while the queue has room; during a kept frame's
// header burst in the back end the command queue absorbs incoming bytes and the input
// stalls once it fills (depth FIFO_DEPTH).
// Reset: synchronous active-low rst_n clears counters, flags, queue and output valid;
// the last sequence word resets to 123. No clearing pass, ready the cycle after reset.
module wifi_to_ethernet_decap_top #(
  parameter int FIFO_DEPTH = w2e_pkg::W2E_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  w2e_in_if.sink      in_if,
  w2e_out_if.source   out_if
);
  import w2e_pkg::*;

  w2e_cmd_t      push_cmd;
  w2e_cmd_t      pop_cmd;
  w2e_push_ctl_t push_ctl;
  w2e_pop_ctl_t  pop_ctl;
  logic          q_full;
  logic          q_empty;

  w2e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_ctl_o (push_ctl),
    .full_i     (q_full),
    .cmd_o      (push_cmd)
  );

  w2e_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_ctl.push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop_ctl.pop),
    .pop_data  (pop_cmd),
    .empty     (q_empty)
  );

  w2e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (pop_cmd),
    .empty_i   (q_empty),
    .pop_ctl_o (pop_ctl),
    .out_if    (out_if)
  );

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_ctl.push |-> !push_ctl.full)
    else $error("front pushed into a full queue");
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ctl.pop |-> !pop_ctl.empty)
    else $error("back popped an empty queue");
`endif

endmodule

@@ src/w2e_fifo.sv @@
module w2e_fifo #(
  parameter int DEPTH = w2e_pkg::W2E_FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  w2e_pkg::w2e_cmd_t    push_data,
  output logic                 full,
  input  logic                 pop,
  output w2e_pkg::w2e_cmd_t    pop_data,
  output logic                 empty
);
  import w2e_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  w2e_cmd_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= FULL_CNT)
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && full && !pop |=> cnt_r == FULL_CNT)
    else $error("queue count moved on a push into a full queue");
`endif

endmodule

@@ src/w2e_front.sv @@
module w2e_front (
  input  logic                 clk,
  input  logic                 rst_n,
  w2e_in_if.sink               in_if,
  output w2e_pkg::w2e_push_ctl_t push_ctl_o,
  input  logic                 full_i,
  output w2e_pkg::w2e_cmd_t    cmd_o
);
  import w2e_pkg::*;

  logic [5:0]  cnt_r, cnt_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  seq_lo_r, seq_lo_nxt;
  logic [15:0] prev_seq_r, prev_seq_nxt;
  logic        drop_r, drop_nxt;
  logic [7:0]  addr_r [ADDR_BYTES];

  logic        acc;
  logic [15:0] seq_word;
  logic [5:0]  kind_field;
  logic [5:0]  offset;
  logic [3:0]  addr_idx;
  logic        emit_hdr, emit_pay;

  assign in_if.ready = !full_i;
  assign acc         = in_if.valid && in_if.ready;
  assign seq_word    = {in_if.in_byte, seq_lo_r};
  assign addr_idx    = 4'(cnt_r - 6'd4);

  always_comb begin
    kind_nxt     = kind_r;
    seq_lo_nxt   = seq_lo_r;
    prev_seq_nxt = prev_seq_r;
    drop_nxt     = drop_r;
    kind_field   = in_if.in_byte[7:2] & KIND_MASK;
    if (cnt_r == 6'd0) begin
      kind_nxt = in_if.in_byte;
      drop_nxt = !(kind_field == KIND_DATA || kind_field == KIND_QOS);
    end
    if (cnt_r == 6'd22) begin
      seq_lo_nxt = in_if.in_byte;
    end
    // Duplicate check on the full sequence word
    if (cnt_r == 6'd23) begin
      if (seq_word == prev_seq_r) begin
        drop_nxt = 1'b1;
      end else begin
        prev_seq_nxt = seq_word;
      end
    end
    offset   = ((kind_nxt[7:2] & KIND_MASK) == KIND_QOS) ? OFF_QOS : OFF_DATA;
    emit_hdr = !drop_nxt && (cnt_r == offset - 6'd1);
    emit_pay = !drop_nxt && (cnt_r >= offset);

    if (in_if.in_last) begin
      cnt_nxt = '0;
    end else if (cnt_r < COUNT_CEIL) begin
      cnt_nxt = cnt_r + 6'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    cmd_o.hdr  = emit_hdr;
    cmd_o.data = in_if.in_byte;
    cmd_o.last = in_if.in_last;
    for (int i = 0; i < ADDR_BYTES; i++) begin
      cmd_o.addr[i*8 +: 8] = addr_r[i];
    end
  end

  assign push_ctl_o.push = acc && (emit_hdr || emit_pay);
  assign push_ctl_o.full = full_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      kind_r     <= '0;
      seq_lo_r   <= '0;
      prev_seq_r <= SEQ_RESET;
      drop_r     <= 1'b0;
    end else if (acc) begin
      cnt_r      <= cnt_nxt;
      kind_r     <= kind_nxt;
      seq_lo_r   <= seq_lo_nxt;
      prev_seq_r <= prev_seq_nxt;
      drop_r     <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && cnt_r >= 6'd4 && cnt_r < 6'd16) begin
      addr_r[addr_idx] <= in_if.in_byte;
    end
  end

`ifndef SYNTH
  a_cnt_ceil: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= COUNT_CEIL)
    else $error("byte counter past ceiling");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_if.in_last |=> cnt_r == 6'd0)
    else $error("byte counter not cleared after last item");
`endif

endmodule

@@ src/w2e_back.sv @@
module w2e_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  w2e_pkg::w2e_cmd_t    cmd_i,
  input  logic                 empty_i,
  output w2e_pkg::w2e_pop_ctl_t pop_ctl_o,
  w2e_out_if.source            out_if
);
  import w2e_pkg::*;

  localparam logic [3:0] HDR_LAST_IDX = 4'(HDR_LEN - 1);
  localparam logic [3:0] ETYPE_LO_IDX = 4'(ADDR_BYTES);

  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_byte_r, out_byte_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    hdr_act_r, hdr_act_nxt;
  logic [3:0]              hdr_idx_r, hdr_idx_nxt;
  logic                    hdr_last_r, hdr_last_nxt;
  logic [ADDR_BYTES*8-1:0] hdr_addr_r, hdr_addr_nxt;
  logic                    slot_free;
  logic                    pop;

  assign slot_free = !out_valid_r || out_if.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    hdr_act_nxt   = hdr_act_r;
    hdr_idx_nxt   = hdr_idx_r;
    hdr_last_nxt  = hdr_last_r;
    hdr_addr_nxt  = hdr_addr_r;
    pop           = 1'b0;
    if (slot_free) begin
      if (hdr_act_r) begin
        // Finish the header burst
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b0;
        if (hdr_idx_r < ETYPE_LO_IDX) begin
          out_byte_nxt = hdr_addr_r[hdr_idx_r*8 +: 8];
        end else if (hdr_idx_r == ETYPE_LO_IDX) begin
          out_byte_nxt = ETYPE_WORD[7:0];
        end else begin
          out_byte_nxt = ETYPE_WORD[15:8];
          out_last_nxt = hdr_last_r;
        end
        if (hdr_idx_r == HDR_LAST_IDX) begin
          hdr_act_nxt = 1'b0;
        end
        hdr_idx_nxt = hdr_idx_r + 4'd1;
      end else if (!empty_i) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        if (cmd_i.hdr) begin
          out_byte_nxt = cmd_i.addr[7:0];
          out_last_nxt = 1'b0;
          hdr_act_nxt  = 1'b1;
          hdr_idx_nxt  = 4'd1;
          hdr_last_nxt = cmd_i.last;
          hdr_addr_nxt = cmd_i.addr;
        end else begin
          out_byte_nxt = cmd_i.data;
          out_last_nxt = cmd_i.last;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  assign pop_ctl_o.pop   = pop;
  assign pop_ctl_o.empty = empty_i;

  assign out_if.valid    = out_valid_r;
  assign out_if.out_byte = out_byte_r;
  assign out_if.out_last = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hdr_act_r   <= 1'b0;
      hdr_idx_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hdr_act_r   <= hdr_act_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    hdr_last_r <= hdr_last_nxt;
    hdr_addr_r <= hdr_addr_nxt;
  end

`ifndef SYNTH
  a_hdr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_act_r |-> (hdr_idx_r >= 4'd1 && hdr_idx_r <= HDR_LAST_IDX))
    else $error("header index out of range during burst");
  a_no_pop_in_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_act_r |-> !pop)
    else $error("queue popped during header burst");
`endif

endmodule
